/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the queue occupancy pacer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define QOP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// A condition that must never be seen at a rising edge outside reset.
`define QOP_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);

`endif

/* rtl/qop_pkg.sv */
// ---------------------------------------------------------------------------
// qop_pkg
// Types, constants and helper functions of the queue occupancy pacer.
// ---------------------------------------------------------------------------
package qop_pkg;

    // Field widths.
    localparam int OCC_W    = 16;
    localparam int PKT_W    = 32;
    localparam int TIME_W   = 48;
    localparam int FUNC_W   = 2;
    localparam int PERIOD_W = 32;
    localparam int TOTAL_W  = 64;
    localparam int QCNT_W   = 32;

    // Register bus.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_MIN_OCC = 2'd0;
    localparam logic [1:0] REG_MAX_OCC = 2'd1;
    localparam logic [1:0] REG_PERIOD  = 2'd2;

    // Reset values.
    localparam logic [OCC_W-1:0]    MIN_OCC_RST = 16'd1;
    localparam logic [OCC_W-1:0]    MAX_OCC_RST = 16'd1024;
    localparam logic [PERIOD_W-1:0] PERIOD_RST  = 32'd10000;
    localparam logic [OCC_W-1:0]    TARGET_RST  = 16'd1024;

    // Event kinds.
    localparam logic [FUNC_W-1:0] FN_SATURATE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DEQUEUE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY    = 2'd2;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [OCC_W-1:0]    min_occ;
        logic [OCC_W-1:0]    max_occ;
        logic [PERIOD_W-1:0] period;
    } qop_cfg_t;

    // Request to the shared divider.
    typedef struct packed {
        logic               start;
        logic [TOTAL_W-1:0] dividend;
        logic [QCNT_W-1:0]  divisor;
    } div_req_t;

    // Answer from the shared divider.
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [TOTAL_W-1:0] quotient;
        logic               rem_nz;
    } div_rsp_t;

    // Clamp a wide value into [lo, hi]; the lower bound is tested first.
    function automatic logic [OCC_W-1:0] clamp_occ(input logic [TOTAL_W-1:0] v,
                                                   input logic [OCC_W-1:0]   lo,
                                                   input logic [OCC_W-1:0]   hi);
        logic [OCC_W-1:0] res;
        if (v < {{(TOTAL_W-OCC_W){1'b0}}, lo}) begin
            res = lo;
        end else if (v > {{(TOTAL_W-OCC_W){1'b0}}, hi}) begin
            res = hi;
        end else begin
            res = v[OCC_W-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/qop_regs.sv */
// ---------------------------------------------------------------------------
// qop_regs
// Register bank of the pacer: clamp bounds and window period over APB.
// ---------------------------------------------------------------------------
module qop_regs
    import qop_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output qop_cfg_t              cfg
);

    logic [OCC_W-1:0]    min_reg,    min_next;
    logic [OCC_W-1:0]    max_reg,    max_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                wr_en;
    logic [1:0]          idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[3:2];

    // Write decode.
    always_comb begin
        min_next    = min_reg;
        max_next    = max_reg;
        period_next = period_reg;
        if (wr_en) begin
            case (idx)
                REG_MIN_OCC: min_next    = pwdata[OCC_W-1:0];
                REG_MAX_OCC: max_next    = pwdata[OCC_W-1:0];
                REG_PERIOD:  period_next = pwdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg    <= MIN_OCC_RST;
            max_reg    <= MAX_OCC_RST;
            period_reg <= PERIOD_RST;
        end else begin
            min_reg    <= min_next;
            max_reg    <= max_next;
            period_reg <= period_next;
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (idx)
            REG_MIN_OCC: prdata = {{(APB_DATA_W-OCC_W){1'b0}}, min_reg};
            REG_MAX_OCC: prdata = {{(APB_DATA_W-OCC_W){1'b0}}, max_reg};
            REG_PERIOD:  prdata = period_reg;
            default:     prdata = '0;
        endcase
    end

    assign cfg.min_occ = min_reg;
    assign cfg.max_occ = max_reg;
    assign cfg.period  = period_reg;

endmodule

/* rtl/qop_divider.sv */
// ---------------------------------------------------------------------------
// qop_divider
// Restoring divider, one quotient bit per cycle, with a remainder flag.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qop_divider
    import qop_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(TOTAL_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic [TOTAL_W-1:0] dvd_reg,  dvd_next;
    logic [QCNT_W-1:0]  rem_reg,  rem_next;
    logic [QCNT_W-1:0]  dvs_reg,  dvs_next;
    logic [QCNT_W:0]    trial;

    // One trial subtraction of the shifted remainder.
    assign trial = {rem_reg, dvd_reg[TOTAL_W-1]} - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            // The quotient bits fill the dividend register from the bottom.
            if (!trial[QCNT_W]) begin
                rem_next = trial[QCNT_W-1:0];
                dvd_next = {dvd_reg[TOTAL_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[QCNT_W-2:0], dvd_reg[TOTAL_W-1]};
                dvd_next = {dvd_reg[TOTAL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(TOTAL_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;
    assign rsp.rem_nz   = |rem_reg;

    // A new division must not arrive while one is running.
    `QOP_ASSERT_NEVER(a_start_busy, aclk, aresetn, req.start && busy_reg,
        "divider started while busy")
    // Completion is reported only once the iterations have stopped.
    `QOP_ASSERT(a_done_idle, aclk, aresetn, done_reg |-> !busy_reg,
        "divider done while busy")
    // Every run ends with a completion pulse.
    `QOP_ASSERT(a_fell_done, aclk, aresetn, $fell(busy_reg) |-> done_reg,
        "divider stopped without done")

endmodule

/* rtl/queue_occupancy_pacer.sv */
// Flow: an accepted request is executed, then its result is loaded into the
// result register once that is free; a recompute over a non-zero query count
// first waits for the 64-step shared divider. One request at a time: the next is
// accepted only after the last result is handed over, so back-pressure holds it.
// Reset: synchronous, active low; control, estimator and configuration state
// return to defaults, the request and result data registers are not reset.
// ---------------------------------------------------------------------------
// queue_occupancy_pacer
// Tracks dequeue rate over a time window and returns a target occupancy.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module queue_occupancy_pacer
    import qop_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Request channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [79:0]           s_tdata,   // packets[31:0], time_us[79:32]
    input  logic [FUNC_W-1:0]     s_tuser,   // func[1:0]
    // Result channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OCC_W-1:0]      m_tdata,   // occupancy[15:0]
    // Register port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    qop_cfg_t cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [1:0]          state_reg,  state_next;
    logic [FUNC_W-1:0]   func_reg,   func_next;
    logic [PKT_W-1:0]    pkts_reg,   pkts_next;
    logic [TIME_W-1:0]   now_reg,    now_next;
    logic                sat_reg,    sat_next;
    logic                boost_reg,  boost_next;
    logic [OCC_W-1:0]    target_reg, target_next;
    logic [TOTAL_W-1:0]  total_reg,  total_next;
    logic [TOTAL_W-1:0]  wbase_reg,  wbase_next;
    logic [QCNT_W-1:0]   qcnt_reg,   qcnt_next;
    logic [TIME_W-1:0]   wstart_reg, wstart_next;
    logic                mval_reg,   mval_next;
    logic [OCC_W-1:0]    occ_reg,    occ_next;

    logic [TIME_W:0]     win_end;
    logic [TIME_W:0]     half_end;
    logic [TOTAL_W-1:0]  ceil_q;

    qop_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qop_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = occ_reg;

    // Window ends, kept one bit wider so the sums never wrap.
    assign win_end  = {1'b0, wstart_reg} + {{(TIME_W+1-PERIOD_W){1'b0}}, cfg.period};
    assign half_end = {1'b0, wstart_reg}
                    + {{(TIME_W+2-PERIOD_W){1'b0}}, cfg.period[PERIOD_W-1:1]};

    // Quotient rounded up; a non-zero remainder implies a divisor above one.
    assign ceil_q = div_rsp.quotient + {{(TOTAL_W-1){1'b0}}, div_rsp.rem_nz};

    always_comb begin
        state_next       = state_reg;
        func_next        = func_reg;
        pkts_next        = pkts_reg;
        now_next         = now_reg;
        sat_next         = sat_reg;
        boost_next       = boost_reg;
        target_next      = target_reg;
        total_next       = total_reg;
        wbase_next       = wbase_reg;
        qcnt_next        = qcnt_reg;
        wstart_next      = wstart_reg;
        mval_next        = mval_reg & ~m_tready;
        occ_next         = occ_reg;
        div_req.start    = 1'b0;
        div_req.dividend = total_reg - wbase_reg;
        div_req.divisor  = qcnt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tuser;
                    pkts_next  = s_tdata[PKT_W-1:0];
                    now_next   = s_tdata[PKT_W+TIME_W-1:PKT_W];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                case (func_reg)
                    FN_SATURATE: begin
                        sat_next = 1'b1;
                    end
                    FN_DEQUEUE: begin
                        // A recompute or an early dequeue restarts the window.
                        if (sat_reg || (win_end > {1'b0, now_reg})) begin
                            wbase_next  = total_reg;
                            qcnt_next   = '0;
                            boost_next  = 1'b0;
                            wstart_next = now_reg;
                        end
                        if (sat_reg) begin
                            sat_next = 1'b0;
                            if (qcnt_reg == '0) begin
                                target_next = clamp_occ('1, cfg.min_occ, cfg.max_occ);
                            end else begin
                                div_req.start = 1'b1;
                                state_next    = ST_DIV;
                            end
                        end
                        total_next = total_reg + {{(TOTAL_W-PKT_W){1'b0}}, pkts_reg};
                    end
                    FN_QUERY: begin
                        if (qcnt_reg != '1) begin
                            qcnt_next = qcnt_reg + 1'b1;
                        end
                        // Early in the window the target is doubled once.
                        if ((half_end > {1'b0, now_reg}) && !boost_reg) begin
                            boost_next  = 1'b1;
                            target_next = clamp_occ(
                                {{(TOTAL_W-OCC_W-1){1'b0}}, target_reg, 1'b0},
                                cfg.min_occ, cfg.max_occ);
                        end
                    end
                    default: ;
                endcase
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    target_next = clamp_occ(ceil_q, cfg.min_occ, cfg.max_occ);
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hand the target over once the result register is free.
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    occ_next   = target_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sat_reg    <= 1'b0;
            boost_reg  <= 1'b0;
            target_reg <= TARGET_RST;
            total_reg  <= '0;
            wbase_reg  <= '0;
            qcnt_reg   <= '0;
            wstart_reg <= '0;
            mval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sat_reg    <= sat_next;
            boost_reg  <= boost_next;
            target_reg <= target_next;
            total_reg  <= total_next;
            wbase_reg  <= wbase_next;
            qcnt_reg   <= qcnt_next;
            wstart_reg <= wstart_next;
            mval_reg   <= mval_next;
        end
        func_reg <= func_next;
        pkts_reg <= pkts_next;
        now_reg  <= now_next;
        occ_reg  <= occ_next;
    end

    // An accepted request is always executed in the following cycle.
    `QOP_ASSERT(a_accept_exec, aclk, aresetn,
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC),
        "accepted request not executed")
    // The divider is only started by a dequeue that finds the flag set.
    `QOP_ASSERT(a_div_start, aclk, aresetn,
        div_req.start |-> ((state_reg == ST_EXEC) && (func_reg == FN_DEQUEUE) && sat_reg),
        "divider started without a recompute")
    // The saturation flag is already clear while the divider runs.
    `QOP_ASSERT(a_div_flag, aclk, aresetn, (state_reg == ST_DIV) |-> !sat_reg,
        "saturation flag set during division")
    // While the sequencer waits, the divider is either running or just finished.
    `QOP_ASSERT(a_div_wait, aclk, aresetn,
        (state_reg == ST_DIV) |-> (div_rsp.busy || div_rsp.done),
        "sequencer waiting on an idle divider")
    // A new result appears only from the completion state.
    `QOP_ASSERT(a_result_src, aclk, aresetn,
        $rose(mval_reg) |-> $past(state_reg == ST_DONE),
        "result raised outside completion")

endmodule

/* dv/tb_queue_occupancy_pacer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_queue_occupancy_pacer
// Self-checking bench for the queue occupancy pacer. Saturation, dequeue and
// query requests go in over the request stream. A predictor in the bench
// tracks the window, dequeue totals, query count and target, and works out
// the occupancy that each request should return. Results are checked in
// order. Both stream sides idle at random, and the clamp bounds and window
// length are rewritten between phases over the register port.
// ---------------------------------------------------------------------------
module tb_queue_occupancy_pacer;
    import qop_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 27;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_GAP   = 80;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PKT_W-1:0]  packets;
        logic [TIME_W-1:0] now;
    } pacer_request_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [79:0]           s_tdata  = '0;   // packets[31:0], time_us[79:32]
    logic [FUNC_W-1:0]     s_tuser  = '0;   // func[1:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OCC_W-1:0]      m_tdata;         // occupancy[15:0]
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    queue_occupancy_pacer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Stimulus and expectations.
    pacer_request_t   pending_requests[$];
    pacer_request_t   next_request;
    logic [OCC_W-1:0] expected_occupancy[$];
    logic [TIME_W-1:0] clock_now;

    // Shadow of the registers and of the estimator state.
    logic [OCC_W-1:0]    cfg_min;
    logic [OCC_W-1:0]    cfg_max;
    logic [PERIOD_W-1:0] cfg_period;
    logic                est_saturated;
    logic                est_boosted;
    logic [OCC_W-1:0]    est_target;
    logic [TOTAL_W-1:0]  est_total;
    logic [TOTAL_W-1:0]  est_total_at_start;
    logic [QCNT_W-1:0]   est_queries;
    logic [TIME_W-1:0]   est_window_start;

    int error_count       = 0;
    int requests_accepted = 0;
    int results_checked   = 0;
    int recompute_count   = 0;
    int boost_count       = 0;
    int holds_started     = 0;
    int hold_left         = 0;
    int cycle_count       = 0;
    logic calm;

    // A stretch where neither side idles.
    assign calm = (requests_accepted >= 1000) && (requests_accepted < 1200);

    function automatic logic [OCC_W-1:0] bound_target(input logic [TOTAL_W-1:0] v);
        logic [OCC_W-1:0] r;
        if (v < {48'd0, cfg_min}) begin
            r = cfg_min;
        end else if (v > {48'd0, cfg_max}) begin
            r = cfg_max;
        end else begin
            r = v[OCC_W-1:0];
        end
        return r;
    endfunction

    task automatic restart_window(input logic [TIME_W-1:0] now);
        est_total_at_start = est_total;
        est_queries        = '0;
        est_boosted        = 1'b0;
        est_window_start   = now;
    endtask

    // Advances the estimator by one request and records the occupancy it returns.
    task automatic estimate_occupancy(input pacer_request_t req);
        logic [TOTAL_W-1:0] span;
        logic [TOTAL_W-1:0] quotient;
        logic [TOTAL_W-1:0] window_end;
        logic [TOTAL_W-1:0] half_end;
        span       = est_total - est_total_at_start;
        window_end = {16'd0, est_window_start} + {32'd0, cfg_period};
        half_end   = {16'd0, est_window_start} + {33'd0, cfg_period[PERIOD_W-1:1]};
        case (req.func)
            FN_SATURATE: begin
                est_saturated = 1'b1;
            end
            FN_DEQUEUE: begin
                if (est_saturated) begin
                    est_saturated = 1'b0;
                    if (est_queries == '0) begin
                        quotient = '1;
                    end else begin
                        quotient = span / {32'd0, est_queries};
                        if (span % {32'd0, est_queries} != 0) quotient = quotient + 1;
                    end
                    est_target = bound_target(quotient);
                    restart_window(req.now);
                    recompute_count++;
                end else if (window_end > {16'd0, req.now}) begin
                    restart_window(req.now);
                end
                est_total = est_total + {32'd0, req.packets};
            end
            FN_QUERY: begin
                if (est_queries != '1) est_queries = est_queries + 1;
                if (half_end > {16'd0, req.now} && !est_boosted) begin
                    est_boosted = 1'b1;
                    est_target  = bound_target({47'd0, est_target, 1'b0});
                    boost_count++;
                end
            end
            default: begin
            end
        endcase
        expected_occupancy.push_back(est_target);
    endtask

    task automatic report_mismatch(input string what, input logic [OCC_W-1:0] got,
                                   input logic [OCC_W-1:0] want);
        $display("ERROR %0t: %s: occupancy got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Request driver: offers the next pending request, idling at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                next_request = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {next_request.now, next_request.packets};
                s_tuser  <= next_request.func;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus two long hold-offs that fill the block.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_started < 2 && requests_accepted >= 200 + 600 * holds_started) begin
            holds_started <= holds_started + 1;
            hold_left     <= HOLD_CYCLES;
            m_tready      <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Each accepted request feeds the predictor.
    always @(posedge aclk) begin : request_monitor
        pacer_request_t seen;
        if (aresetn && s_tvalid && s_tready) begin
            seen.func    = s_tuser;
            seen.packets = s_tdata[31:0];
            seen.now     = s_tdata[79:32];
            estimate_occupancy(seen);
            requests_accepted++;
        end
    end

    // Each accepted result is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_occupancy.size() == 0) begin
                report_mismatch("result with no request outstanding", m_tdata, '0);
            end else begin
                if (m_tdata !== expected_occupancy[0]) begin
                    report_mismatch("wrong result", m_tdata, expected_occupancy[0]);
                end
                void'(expected_occupancy.pop_front());
            end
            results_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
                     expected_occupancy.size());
            $display("FAIL queue_occupancy_pacer");
            $finish;
        end
    end

    task automatic add_request(input logic [FUNC_W-1:0] func, input logic [PKT_W-1:0] packets,
                               input logic [TIME_W-1:0] now);
        pacer_request_t req;
        req.func    = func;
        req.packets = packets;
        req.now     = now;
        pending_requests.push_back(req);
    endtask

    // Mostly ordered time with dequeues, queries and saturations; a few
    // unused codes and requests with arbitrary time as noise.
    task automatic add_random_requests(input int count, input int step_max);
        int pick;
        int size_pick;
        logic [PKT_W-1:0]  packets;
        logic [FUNC_W-1:0] func;
        logic [TIME_W-1:0] now;
        repeat (count) begin
            pick      = $urandom_range(99);
            size_pick = $urandom_range(99);
            clock_now = clock_now + $urandom_range(step_max);
            now       = clock_now;
            if (size_pick < 70) begin
                packets = $urandom_range(40);
            end else if (size_pick < 90) begin
                packets = $urandom_range(4000);
            end else begin
                packets = $urandom();
            end
            if (pick < 40) begin
                func = FN_DEQUEUE;
            end else if (pick < 75) begin
                func = FN_QUERY;
            end else if (pick < 90) begin
                func = FN_SATURATE;
            end else if (pick < 94) begin
                func = FN_UNUSED;
            end else begin
                func = FUNC_W'($urandom_range(3));
                now  = {16'($urandom_range(65535)), $urandom()};
            end
            add_request(func, packets, now);
        end
    endtask

    // Waits until every request has gone in and every result has come back.
    task automatic wait_until_idle();
        while (pending_requests.size() > 0 || s_tvalid || expected_occupancy.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_MIN_OCC: cfg_min    = value[OCC_W-1:0];
            REG_MAX_OCC: cfg_max    = value[OCC_W-1:0];
            REG_PERIOD:  cfg_period = value;
            default: begin
            end
        endcase
    endtask

    task automatic configure(input logic [OCC_W-1:0] lo, input logic [OCC_W-1:0] hi,
                             input logic [PERIOD_W-1:0] period);
        write_register(REG_MIN_OCC, {16'd0, lo});
        write_register(REG_MAX_OCC, {16'd0, hi});
        write_register(REG_PERIOD, period);
    endtask

    initial begin : stimulus
        logic [PERIOD_W-1:0] period;
        cfg_min            = MIN_OCC_RST;
        cfg_max            = MAX_OCC_RST;
        cfg_period         = PERIOD_RST;
        est_saturated      = 1'b0;
        est_boosted        = 1'b0;
        est_target         = TARGET_RST;
        est_total          = '0;
        est_total_at_start = '0;
        est_queries        = '0;
        est_window_start   = '0;
        clock_now          = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests under the reset settings.
        add_request(FN_QUERY,    32'd0,          48'd0);      // doubling clamps at max
        add_request(FN_QUERY,    32'd0,          48'd1);      // only one boost per window
        add_request(FN_SATURATE, 32'd0,          48'd2);
        add_request(FN_DEQUEUE,  32'd0,          48'd3);      // zero dequeued clamps to min
        add_request(FN_SATURATE, 32'hFFFF_FFFF,  48'd4);
        add_request(FN_DEQUEUE,  32'hFFFF_FFFF,  48'd4);      // no queries counts as maximum
        add_request(FN_DEQUEUE,  32'hFFFF_FFFF,  48'd5);      // inside window: restart
        add_request(FN_QUERY,    32'd0,          48'd6);
        add_request(FN_DEQUEUE,  32'd7,          48'd20000);  // window expired: no restart
        add_request(FN_QUERY,    32'd0,          48'd20001);  // past half window: no boost
        add_request(FN_QUERY,    32'd0,          48'd20002);
        add_request(FN_SATURATE, 32'd0,          48'd20003);
        add_request(FN_DEQUEUE,  32'd0,          48'd20003);  // huge quotient clamps to max
        add_request(FN_UNUSED,   32'hFFFF_FFFF,  48'hFFFF_FFFF_FFFF);
        add_request(FN_QUERY,    32'd0,          48'hFFFF_FFFF_FFFF);
        add_request(FN_SATURATE, 32'd0,          48'hFFFF_FFFF_FFFF);
        add_request(FN_DEQUEUE,  32'd0,          48'hFFFF_FFFF_FFFF);
        add_request(FN_QUERY,    32'd0,          48'd0);      // window end beyond 48 bits
        add_request(FN_DEQUEUE,  32'd1,          48'hFFFF_FFFF_FFFF);
        add_request(FN_DEQUEUE,  32'd10,         48'd100);
        add_request(FN_QUERY,    32'd0,          48'd101);
        add_request(FN_QUERY,    32'd0,          48'd102);
        add_request(FN_QUERY,    32'd0,          48'd103);
        add_request(FN_SATURATE, 32'd0,          48'd104);
        add_request(FN_DEQUEUE,  32'd0,          48'd105);    // ten over three rounds up
        wait_until_idle();

        // Widest clamp range and a zero-length window.
        configure(16'd0, 16'hFFFF, 32'd0);
        clock_now = 48'd1000;
        add_random_requests(250, 3);
        wait_until_idle();

        // Narrow range, short window; the sender pauses halfway until drained.
        configure(16'd2, 16'd500, 32'd200);
        add_random_requests(200, 60);
        wait_until_idle();
        add_random_requests(200, 60);
        wait_until_idle();

        // Minimum above maximum, longest window, time near the top of its range.
        configure(16'hFFFF, 16'd0, 32'hFFFF_FFFF);
        clock_now = 48'hFFFF_FFF0_0000;
        add_random_requests(100, 2000);
        wait_until_idle();

        // Random settings.
        period = $urandom_range(10, 5000);
        configure(16'($urandom_range(20)), 16'($urandom_range(100, 3000)), period);
        clock_now = {16'($urandom_range(255)), $urandom()};
        add_random_requests(400, period / 8 + 1);
        wait_until_idle();

        // Back to the reset values.
        configure(MIN_OCC_RST, MAX_OCC_RST, PERIOD_RST);
        clock_now = '0;
        add_random_requests(280, 1500);
        wait_until_idle();

        $display("Checked %0d results from %0d requests over six register settings.",
                 results_checked, requests_accepted);
        $display("Target recomputed %0d times, boosted %0d times, %0d mismatches.",
                 recompute_count, boost_count, error_count);
        if (error_count == 0) begin
            $display("PASS queue_occupancy_pacer");
        end else begin
            $display("FAIL queue_occupancy_pacer");
        end
        $finish;
    end

endmodule
